### hw/rtl/gpm_pkg.sv
// ============================================================================
// gpm_pkg - shared types and constants for the glob pattern matcher
// Token kinds, request codes, pattern byte codes and sequencer states.
// ============================================================================
package gpm_pkg;

  // Request codes carried on the slave tuser field
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TEXT   = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Token kinds
  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_ANY   = 2'd1;
  localparam logic [1:0] KIND_CLASS = 2'd2;
  localparam logic [1:0] KIND_STAR  = 2'd3;

  // Pattern syntax bytes
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // Follow-up work after a scan or a compile
  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_TEXT = 2'd1,
    JOB_OUT  = 2'd2
  } job_t;

  // Sequencer states, one-hot
  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_CWAIT  = 16'h0002,
    ST_TOK    = 16'h0004,
    ST_STAR   = 16'h0008,
    ST_ESC    = 16'h0010,
    ST_NEG    = 16'h0020,
    ST_CLS    = 16'h0040,
    ST_FIRST  = 16'h0080,
    ST_DASH   = 16'h0100,
    ST_DASH2  = 16'h0200,
    ST_LAST   = 16'h0400,
    ST_RANGE  = 16'h0800,
    ST_SSTART = 16'h1000,
    ST_SWAIT  = 16'h2000,
    ST_SEVAL  = 16'h4000,
    ST_OUT    = 16'h8000
  } state_t;

endpackage

### hw/rtl/glob_pattern_matcher_unit.sv
// ============================================================================
// glob_pattern_matcher_unit - glob pattern matcher
// Stores a glob pattern, compiles it to tokens and matches streamed text.
// ============================================================================
// Requests arrive on the slave stream: tuser selects append pattern byte,
// text byte, end of text or clear pattern, and tdata carries the byte. One
// result (matched, pattern_overflow) leaves on the master stream per end of
// text. Everything runs on one sequencer that reads one pattern byte or one
// token per step from registered memories. The first text byte or end of
// text after a pattern edit compiles the pattern unless it has overflowed
// (an unclosed bracket makes its bytes scan a second time) and then resets
// the active token set. A text byte then runs one pass over the tokens; an
// end of text waits for the result to be taken and then resets the active
// token set. Pattern appends and clears complete in the cycle that accepts
// them. The block accepts no request while it is busy.
// ============================================================================
module glob_pattern_matcher_unit #(
  parameter int PATTERN_MAX = 64,
  parameter int TOKEN_MAX   = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [1:0] op
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import gpm_pkg::*;

  localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LW  = $clog2(PATTERN_MAX + 1);
  localparam int TAW = (TOKEN_MAX > 1) ? $clog2(TOKEN_MAX) : 1;
  localparam int TCW = $clog2(TOKEN_MAX + 1);

  // Memories
  logic [7:0]   pat_mem [PATTERN_MAX];
  logic [1:0]   kind_mem [TOKEN_MAX];
  logic [7:0]   byte_mem [TOKEN_MAX];
  logic [255:0] cls_mem [TOKEN_MAX];
  logic [7:0]   pat_rd;
  logic [1:0]   kind_rd;
  logic [7:0]   byte_rd;
  logic [255:0] cls_rd;

  // Control and datapath registers
  state_t         state, ret;
  job_t           job;
  logic [LW-1:0]  len, p, s_pos;
  logic           ovf, compiled, rmode, neg, accept;
  logic [TCW-1:0] n, total, idx;
  logic [7:0]     tbyte, first, last;
  logic [255:0]   class_acc;
  logic [TOKEN_MAX:0] act, nxt;

  // Combinational helpers
  logic           accept_req, pat_we;
  logic [7:0]     bval;
  logic           p_in, p1_in;
  logic           tok_we;
  logic [1:0]     tok_wkind;
  logic [7:0]     tok_wbyte;
  logic [255:0]   range_mask;
  logic           a_i, is_star, tok_acc, n_i;
  logic [TCW-1:0] idx1;
  logic [TOKEN_MAX:0] nxt_upd;

  assign s_tready   = (state == ST_IDLE);
  assign accept_req = s_tvalid && s_tready;
  assign pat_we     = accept_req && (s_tuser == OP_APPEND) && (s_tdata != 8'd0)
                      && ((LW+1)'(len) < (LW+1)'(PATTERN_MAX));

  // Pattern store
  always_ff @(posedge clk) begin
    if (pat_we) pat_mem[len[PAW-1:0]] <= s_tdata;
    pat_rd <= pat_mem[p[PAW-1:0]];
  end

  // Token store
  always_ff @(posedge clk) begin
    if (tok_we) begin
      kind_mem[n[TAW-1:0]] <= tok_wkind;
      byte_mem[n[TAW-1:0]] <= tok_wbyte;
      cls_mem[n[TAW-1:0]]  <= neg ? ~class_acc : class_acc;
    end
    kind_rd <= kind_mem[idx[TAW-1:0]];
    byte_rd <= byte_mem[idx[TAW-1:0]];
    cls_rd  <= cls_mem[idx[TAW-1:0]];
  end

  // Pattern byte at the compile position, zero past the end
  always_comb begin
    p_in  = (p < len);
    p1_in = ((LW+1)'(p) + (LW+1)'(1)) < (LW+1)'(len);
    bval  = p_in ? pat_rd : 8'd0;
  end

  // Token write decode
  always_comb begin
    tok_we    = 1'b0;
    tok_wkind = KIND_LIT;
    tok_wbyte = 8'd0;
    unique case (state)
      ST_TOK: begin
        if (p_in && ((TCW+1)'(n) < (TCW+1)'(TOKEN_MAX))) begin
          if (bval == CH_STAR) begin
            tok_we    = 1'b1;
            tok_wkind = KIND_STAR;
          end else if (bval == CH_QUEST) begin
            tok_we    = 1'b1;
            tok_wkind = KIND_ANY;
          end else if (bval == CH_LBRK) begin
            tok_we = 1'b0;
          end else if (bval == CH_BSL && p1_in) begin
            tok_we = 1'b0;
          end else begin
            tok_we    = 1'b1;
            tok_wbyte = bval;
          end
        end
      end
      ST_ESC: begin
        tok_we    = 1'b1;
        tok_wbyte = bval;
      end
      ST_CLS: begin
        if (!p_in) begin
          tok_we    = 1'b1;
          tok_wbyte = CH_LBRK;
        end else if (bval == CH_RBRK) begin
          tok_we    = 1'b1;
          tok_wkind = KIND_CLASS;
        end
      end
      default: tok_we = 1'b0;
    endcase
  end

  // Inclusive range mask for a class range
  always_comb begin
    for (int v = 0; v < 256; v++) begin
      range_mask[v] = (8'(v) >= first) && (8'(v) <= last);
    end
  end

  // One token step of the active set update with star closure
  always_comb begin
    idx1    = idx + TCW'(1);
    a_i     = act[idx];
    is_star = (kind_rd == KIND_STAR);
    case (kind_rd)
      KIND_LIT:   tok_acc = (byte_rd == tbyte);
      KIND_ANY:   tok_acc = 1'b1;
      KIND_CLASS: tok_acc = cls_rd[tbyte];
      default:    tok_acc = 1'b0;
    endcase
    n_i           = nxt[idx] | (a_i & is_star);
    nxt_upd       = nxt;
    nxt_upd[idx]  = n_i;
    nxt_upd[idx1] = nxt[idx1] | (n_i & is_star) | (a_i & ~is_star & tok_acc);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret      <= ST_IDLE;
      job      <= JOB_NONE;
      len      <= '0;
      ovf      <= 1'b0;
      compiled <= 1'b0;
      total    <= '0;
      rmode    <= 1'b0;
      accept   <= 1'b0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept_req) begin
            case (s_tuser)
              OP_APPEND: begin
                if (s_tdata != 8'd0) begin
                  if (pat_we) len <= len + LW'(1);
                  else ovf <= 1'b1;
                  compiled <= 1'b0;
                end
              end
              OP_TEXT: begin
                if (s_tdata != 8'd0 && !ovf) begin
                  tbyte <= s_tdata;
                  if (!compiled) begin
                    p     <= '0;
                    n     <= '0;
                    job   <= JOB_TEXT;
                    ret   <= ST_TOK;
                    state <= ST_CWAIT;
                  end else begin
                    rmode <= 1'b0;
                    job   <= JOB_NONE;
                    state <= ST_SSTART;
                  end
                end
              end
              OP_END: begin
                if (!ovf && !compiled) begin
                  p     <= '0;
                  n     <= '0;
                  job   <= JOB_OUT;
                  ret   <= ST_TOK;
                  state <= ST_CWAIT;
                end else begin
                  state <= ST_OUT;
                end
              end
              default: begin
                len      <= '0;
                ovf      <= 1'b0;
                compiled <= 1'b0;
                total    <= '0;
              end
            endcase
          end
        end

        // wait for the registered pattern read
        ST_CWAIT: state <= ret;

        ST_TOK: begin
          if (!p_in || ((TCW+1)'(n) >= (TCW+1)'(TOKEN_MAX))) begin
            total    <= n;
            compiled <= 1'b1;
            if (p_in) begin
              ovf   <= 1'b1;
              job   <= JOB_NONE;
              state <= (job == JOB_OUT) ? ST_OUT : ST_IDLE;
            end else begin
              rmode <= 1'b1;
              state <= ST_SSTART;
            end
          end else if (bval == CH_STAR) begin
            n     <= n + TCW'(1);
            p     <= p + LW'(1);
            ret   <= ST_STAR;
            state <= ST_CWAIT;
          end else if (bval == CH_LBRK) begin
            s_pos <= p;
            p     <= p + LW'(1);
            ret   <= ST_NEG;
            state <= ST_CWAIT;
          end else if (bval == CH_BSL && p1_in) begin
            p     <= p + LW'(1);
            ret   <= ST_ESC;
            state <= ST_CWAIT;
          end else begin
            n     <= n + TCW'(1);
            p     <= p + LW'(1);
            ret   <= ST_TOK;
            state <= ST_CWAIT;
          end
        end

        // fold a run of stars into one token
        ST_STAR: begin
          if (p_in && bval == CH_STAR) begin
            p     <= p + LW'(1);
            ret   <= ST_STAR;
            state <= ST_CWAIT;
          end else begin
            state <= ST_TOK;
          end
        end

        ST_ESC: begin
          n     <= n + TCW'(1);
          p     <= p + LW'(1);
          ret   <= ST_TOK;
          state <= ST_CWAIT;
        end

        ST_NEG: begin
          class_acc <= '0;
          if (bval == CH_BANG || bval == CH_CARET) begin
            neg   <= 1'b1;
            p     <= p + LW'(1);
            ret   <= ST_CLS;
            state <= ST_CWAIT;
          end else begin
            neg   <= 1'b0;
            state <= ST_CLS;
          end
        end

        ST_CLS: begin
          if (p_in && bval != CH_RBRK) begin
            first <= bval;
            p     <= p + LW'(1);
            ret   <= ST_FIRST;
            state <= ST_CWAIT;
          end else if (!p_in) begin
            // unterminated class: literal bracket, resume after it
            n     <= n + TCW'(1);
            p     <= s_pos + LW'(1);
            ret   <= ST_TOK;
            state <= ST_CWAIT;
          end else begin
            n     <= n + TCW'(1);
            p     <= p + LW'(1);
            ret   <= ST_TOK;
            state <= ST_CWAIT;
          end
        end

        ST_FIRST: begin
          if (first == CH_BSL && p_in) begin
            first <= bval;
            p     <= p + LW'(1);
            ret   <= ST_DASH;
            state <= ST_CWAIT;
          end else begin
            state <= ST_DASH;
          end
        end

        ST_DASH: begin
          if (bval == CH_DASH && p1_in) begin
            p     <= p + LW'(1);
            ret   <= ST_DASH2;
            state <= ST_CWAIT;
          end else begin
            class_acc[first] <= 1'b1;
            state            <= ST_CLS;
          end
        end

        ST_DASH2: begin
          if (bval != CH_RBRK) begin
            last  <= bval;
            p     <= p + LW'(1);
            ret   <= ST_LAST;
            state <= ST_CWAIT;
          end else begin
            // dash before closing bracket is a member
            class_acc[first] <= 1'b1;
            p                <= p - LW'(1);
            ret              <= ST_CLS;
            state            <= ST_CWAIT;
          end
        end

        ST_LAST: begin
          if (last == CH_BSL && p_in) begin
            last  <= bval;
            p     <= p + LW'(1);
            ret   <= ST_RANGE;
            state <= ST_CWAIT;
          end else begin
            state <= ST_RANGE;
          end
        end

        ST_RANGE: begin
          class_acc <= class_acc | range_mask;
          state     <= ST_CLS;
        end

        // start a pass over the tokens
        ST_SSTART: begin
          idx <= '0;
          if (rmode) begin
            act <= '0;
            nxt <= (TOKEN_MAX+1)'(1);
          end else begin
            nxt <= '0;
          end
          if (total == '0) begin
            act    <= rmode ? (TOKEN_MAX+1)'(1) : '0;
            accept <= rmode;
            if (job == JOB_TEXT) begin
              rmode <= 1'b0;
              job   <= JOB_NONE;
              state <= ST_SSTART;
            end else if (job == JOB_OUT) begin
              state <= ST_OUT;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_SWAIT;
          end
        end

        ST_SWAIT: state <= ST_SEVAL;

        ST_SEVAL: begin
          nxt <= nxt_upd;
          if (idx1 == total) begin
            act    <= nxt_upd;
            accept <= nxt_upd[idx1];
            if (job == JOB_TEXT) begin
              rmode <= 1'b0;
              job   <= JOB_NONE;
              state <= ST_SSTART;
            end else if (job == JOB_OUT) begin
              state <= ST_OUT;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            idx   <= idx1;
            state <= ST_SWAIT;
          end
        end

        // hand out the result, then restart the active set
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, ovf, (!ovf && accept)};
            rmode    <= 1'b1;
            job      <= JOB_NONE;
            state    <= ST_SSTART;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/gpm_checker.sv
// ============================================================================
// gpm_checker - port-level checks for the glob pattern matcher
// Watches the stream ports of the top level over time.
// ============================================================================
module gpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import gpm_pkg::*;

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // overflow forces a mismatch
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("match reported with overflow");

  // accepting an end of text makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_END |=> !s_tready)
    else $error("ready right after end of text");

  // padding bits stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:2] == 6'd0)
    else $error("result padding not zero");

endmodule

bind glob_pattern_matcher_unit gpm_checker u_gpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
